// ----- hw/rtl/hfd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package hfd_pkg;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_GOOD  = 2'd1,
    KIND_SHORT = 2'd2,
    KIND_BAD   = 2'd3
  } kind_t;

  localparam logic [7:0] LONG_ADDR_MASK_RST = 8'h80;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [7:0]  data_index;
    logic [7:0]  delimiter_byte;
    logic [39:0] address_value;
    logic        long_address;
    logic [7:0]  command_byte;
    logic [7:0]  payload_count;
  } result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/hart_frame_deframer_core.sv -----
// A result is registered into out_r, or into the skid entry while out_r is stalled.
// Throughput: one byte per cycle while in_stall is low; the byte parse and XOR
// sit between the input handshake and a two-entry output register (main plus skid).
// in_stall rises only when both output entries are full.
// Reset (rst_n low, synchronous): waits for a delimiter, output empty,
// long_addr_mask = 0x80.
`timescale 1ns / 1ps
`default_nettype none
module hart_frame_deframer_core
  import hfd_pkg::*;
#(
  parameter int LONG_ADDR_BYTES = 5
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_end_of_buffer,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_result_kind,
  output logic [7:0]       out_data_byte,
  output logic [7:0]       out_data_index,
  output logic [7:0]       out_delimiter_byte,
  output logic [39:0]      out_address_value,
  output logic             out_long_address,
  output logic [7:0]       out_command_byte,
  output logic [7:0]       out_payload_count
);

  localparam int AW = (LONG_ADDR_BYTES > 2) ? $clog2(LONG_ADDR_BYTES) : 1;
  localparam logic [AW-1:0] ADDR_LAST = AW'(LONG_ADDR_BYTES - 1);

  typedef enum logic [2:0] {
    PH_DELIM, PH_ADDR, PH_CMD, PH_COUNT, PH_DATA, PH_CHECK, PH_SKIP
  } phase_t;

  logic [7:0]    mask_r;
  phase_t        phase_r, phase_nxt;
  logic [AW-1:0] addr_seen_r, addr_seen_nxt;
  logic [7:0]    data_seen_r, data_seen_nxt;
  logic [7:0]    xor_r, xor_nxt;
  logic [7:0]    delim_r, delim_nxt;
  logic [39:0]   addr_r, addr_nxt;
  logic [7:0]    cmd_r, cmd_nxt;
  logic [7:0]    count_r, count_nxt;

  result_t out_r, skid_r, res;
  logic    out_valid_r, skid_valid_r;
  logic    res_valid, acc, take, is_long;

  assign acc      = in_valid && !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign take     = out_valid_r && !out_stall;

  always_comb begin
    phase_nxt     = phase_r;
    addr_seen_nxt = addr_seen_r;
    data_seen_nxt = data_seen_r;
    xor_nxt       = xor_r;
    delim_nxt     = delim_r;
    addr_nxt      = addr_r;
    cmd_nxt       = cmd_r;
    count_nxt     = count_r;
    res_valid     = 1'b0;
    res.kind      = KIND_SHORT;
    res.data_byte = 8'd0;
    res.data_index = 8'd0;
    unique case (phase_r)
      PH_DELIM: begin
        delim_nxt     = in_rx_byte;
        addr_nxt      = 40'd0;
        cmd_nxt       = 8'd0;
        count_nxt     = 8'd0;
        addr_seen_nxt = '0;
        data_seen_nxt = 8'd0;
        xor_nxt       = in_rx_byte;
        phase_nxt     = PH_ADDR;
      end
      PH_ADDR: begin
        addr_nxt = {addr_r[31:0], in_rx_byte};
        xor_nxt  = xor_r ^ in_rx_byte;
        if (!((delim_r & mask_r) != 8'd0) || addr_seen_r == ADDR_LAST) begin
          addr_seen_nxt = '0;
          phase_nxt     = PH_CMD;
        end else begin
          addr_seen_nxt = addr_seen_r + AW'(1);
        end
      end
      PH_CMD: begin
        cmd_nxt   = in_rx_byte;
        xor_nxt   = xor_r ^ in_rx_byte;
        phase_nxt = PH_COUNT;
      end
      PH_COUNT: begin
        count_nxt     = in_rx_byte;
        xor_nxt       = xor_r ^ in_rx_byte;
        data_seen_nxt = 8'd0;
        phase_nxt     = (in_rx_byte != 8'd0) ? PH_DATA : PH_CHECK;
      end
      PH_DATA: begin
        xor_nxt       = xor_r ^ in_rx_byte;
        data_seen_nxt = data_seen_r + 8'd1;
        if (data_seen_nxt == count_r) begin
          phase_nxt = PH_CHECK;
        end
        if (!in_end_of_buffer) begin
          res_valid      = 1'b1;
          res.kind       = KIND_DATA;
          res.data_byte  = in_rx_byte;
          res.data_index = data_seen_r;
        end
      end
      PH_CHECK: begin
        res_valid = 1'b1;
        res.kind  = (in_rx_byte == xor_r) ? KIND_GOOD : KIND_BAD;
        phase_nxt = in_end_of_buffer ? PH_DELIM : PH_SKIP;
      end
      PH_SKIP: begin
        if (in_end_of_buffer) begin
          phase_nxt = PH_DELIM;
        end
      end
      default: begin
        phase_nxt = PH_DELIM;
      end
    endcase
    // buffer ended before the checksum
    if (in_end_of_buffer && phase_r != PH_CHECK && phase_r != PH_SKIP) begin
      res_valid = 1'b1;
      res.kind  = KIND_SHORT;
      res.data_byte  = 8'd0;
      res.data_index = 8'd0;
      phase_nxt = PH_DELIM;
    end
    is_long            = (delim_nxt & mask_r) != 8'd0;
    res.delimiter_byte = delim_nxt;
    res.address_value  = addr_nxt;
    res.long_address   = is_long;
    res.command_byte   = cmd_nxt;
    res.payload_count  = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r       <= LONG_ADDR_MASK_RST;
      phase_r      <= PH_DELIM;
      addr_seen_r  <= '0;
      data_seen_r  <= 8'd0;
      xor_r        <= 8'd0;
      delim_r      <= 8'd0;
      addr_r       <= 40'd0;
      cmd_r        <= 8'd0;
      count_r      <= 8'd0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mask_r <= cfg_wdata;
      end
      if (acc) begin
        phase_r     <= phase_nxt;
        addr_seen_r <= addr_seen_nxt;
        data_seen_r <= data_seen_nxt;
        xor_r       <= xor_nxt;
        delim_r     <= delim_nxt;
        addr_r      <= addr_nxt;
        cmd_r       <= cmd_nxt;
        count_r     <= count_nxt;
      end
      if (skid_valid_r) begin
        if (take) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end
      end else if (acc && res_valid) begin
        if (!out_valid_r || take) begin
          out_r       <= res;
          out_valid_r <= 1'b1;
        end else begin
          skid_r       <= res;
          skid_valid_r <= 1'b1;
        end
      end else if (take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_r.kind;
  assign out_data_byte      = out_r.data_byte;
  assign out_data_index     = out_r.data_index;
  assign out_delimiter_byte = out_r.delimiter_byte;
  assign out_address_value  = out_r.address_value;
  assign out_long_address   = out_r.long_address;
  assign out_command_byte   = out_r.command_byte;
  assign out_payload_count  = out_r.payload_count;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_data_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> count_r != 8'd0 && data_seen_r != count_r)
    else $error("data phase with exhausted byte count");

  a_stalled_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("stalled result dropped");

endmodule
`default_nettype wire
